/* sv/orgb_pkg.sv */
package orgb_pkg;

  typedef enum logic {
    DIR_RGB_TO_ORGB = 1'b0,
    DIR_ORGB_TO_RGB = 1'b1
  } dir_t;

  // register byte addresses
  localparam logic [2:0] ADDR_DIRECTION = 3'd0;

  // angles are integers in units of 1e-9 rad
  localparam int ATAN_COUNT = 24;
  localparam int GAIN_BITS  = 30;
  localparam int ANG_W      = 34;

  localparam logic signed [ANG_W-1:0] ANG_PI   = 34'sd3141592654;
  localparam logic signed [ANG_W-1:0] ANG_PI_2 = 34'sd1570796327;
  localparam logic signed [ANG_W-1:0] ANG_PI_3 = 34'sd1047197551;

  localparam logic [29:0] ATAN_TAB [0:ATAN_COUNT-1] = '{
    30'd785398163, 30'd463647609, 30'd244978663, 30'd124354995, 30'd62418810,
    30'd31239833, 30'd15623729, 30'd7812341, 30'd3906230, 30'd1953123,
    30'd976562, 30'd488281, 30'd244141, 30'd122070, 30'd61035, 30'd30518,
    30'd15259, 30'd7629, 30'd3815, 30'd1907, 30'd954, 30'd477, 30'd238, 30'd119
  };

  // floor(v/3) = (v * DIV3_MUL) >> 33, exact for v < 2^32
  localparam logic [31:0] DIV3_MUL = 32'd2863311531;

  // entry n: product of 4^i/(4^i+1) over the first n stages, Q30, each step rounded up
  localparam logic [30:0] GAIN_TAB [0:ATAN_COUNT] = '{
    31'd1073741824, 31'd536870912, 31'd429496730, 31'd404232217, 31'd398013260,
    31'd396464571, 31'd396077777, 31'd395981102, 31'd395956935, 31'd395950894,
    31'd395949384, 31'd395949007, 31'd395948913, 31'd395948890, 31'd395948885,
    31'd395948884, 31'd395948884, 31'd395948884, 31'd395948884, 31'd395948884,
    31'd395948884, 31'd395948884, 31'd395948884, 31'd395948884, 31'd395948884
  };

endpackage

/* sv/rgb_orgb_pixel_converter_unit.sv */
// oRGB pixel converter. direction 0 takes R, G, B (negative G or B read as 0) and returns
// luma, yellow-blue and red-green chroma (chroma saturated to -255..255); direction 1 takes
// L, C1, C2 and returns R, G, B saturated to 0..255. The chroma angle is found by a vectoring
// CORDIC, remapped piecewise and applied by a rotation CORDIC, each ANGLE_STAGES stages deep.
// The pipeline takes one pixel per clock unless a stalled output has filled every stage; a
// result is presented after its pixel passes the 2*ANGLE_STAGES+8 register stages of the two
// unrolled CORDICs and the matrix steps; a stalled output holds only the stages that are full.
// direction should only be written while no pixel is in flight.
module rgb_orgb_pixel_converter_unit
  import orgb_pkg::*;
#(
  parameter int ANGLE_STAGES   = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // chan_a[7:0], chan_b[16:8], chan_c[25:17], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // res_a[7:0], res_b[16:8], res_c[25:17], zero
);

  localparam int N  = ANGLE_STAGES;
  localparam int F  = COEF_FRAC_BITS;
  localparam int XW = F + 13;
  localparam int LW = F + 10;
  localparam int GW = XW + 31;
  localparam int PW = 2 * F + 16;

  localparam int S       = 2 * N + 8;
  localparam int IDX_S1  = 0;
  localparam int IDX_S2  = 1;
  localparam int IDX_R1  = 2 + N;
  localparam int IDX_R2  = 3 + N;
  localparam int IDX_G1  = 4 + 2 * N;
  localparam int IDX_G2  = 5 + 2 * N;
  localparam int IDX_P   = 6 + 2 * N;
  localparam int IDX_O   = 7 + 2 * N;

  localparam longint unsigned K_R   = ((64'd2990 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned K_G   = ((64'd5870 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned K_B   = ((64'd1140 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned K_866 = ((64'd8660 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned K_886 = ((64'd8860 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned K_743 = ((64'd743649 << F) + 64'd500000) / 64'd1000000;
  localparam longint unsigned K_411 = ((64'd411055 << F) + 64'd500000) / 64'd1000000;
  localparam longint unsigned K_166 = ((64'd166282 << F) + 64'd500000) / 64'd1000000;

  localparam logic [LW-1:0]        KL_R   = LW'(K_R);
  localparam logic [LW-1:0]        KL_G   = LW'(K_G);
  localparam logic [LW-1:0]        KL_B   = LW'(K_B);
  localparam logic signed [XW-1:0] KX_866 = XW'(K_866);
  localparam logic signed [PW-1:0] KP_114 = PW'(K_B);
  localparam logic signed [PW-1:0] KP_886 = PW'(K_886);
  localparam logic signed [PW-1:0] KP_743 = PW'(K_743);
  localparam logic signed [PW-1:0] KP_411 = PW'(K_411);
  localparam logic signed [PW-1:0] KP_166 = PW'(K_166);
  localparam logic signed [GW-1:0] GAIN_S = GW'(GAIN_TAB[N]);
  localparam logic signed [GW-1:0] RND_G  = GW'(64'd1 << (GAIN_BITS - 1));
  localparam logic [LW-1:0]        RND_L  = LW'(64'd1 << (F - 1));
  localparam logic signed [XW-1:0] RND_Q  = XW'(64'd1 << (F - 1));
  localparam logic signed [PW-1:0] RND_P  = PW'(64'd1 << (2 * F - 1));

  // configuration
  dir_t direction;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_RGB_TO_ORGB;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_DIRECTION) prdata[0] = direction;
  end

  // stage valids and bubble-collapsing enables
  logic [S-1:0] vld;
  logic [S:0]   en;

  assign en[S] = m_axis_tready;
  for (genvar k = 0; k < S; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[S-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < S; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // side data: luma (or R/L pass-through) and chroma sign
  logic [7:0] sluma [0:IDX_P];
  logic       sneg  [IDX_S2:IDX_P];

  // S1: matrix products and chroma
  logic [7:0]        in_a;
  logic signed [8:0] in_b, in_c;
  logic [7:0]        bc, cc;
  logic signed [9:0] ab_diff;
  logic signed [XW-1:0] c1_f, c2_f, cx_n, cy_n;
  logic [LW-1:0]     s1_lr, s1_lg, s1_lb;
  logic signed [XW-1:0] s1_cx, s1_cy;

  assign in_a = s_axis_tdata[7:0];
  assign in_b = $signed(s_axis_tdata[16:8]);
  assign in_c = $signed(s_axis_tdata[25:17]);

  always_comb begin
    bc      = in_b[8] ? 8'd0 : in_b[7:0];
    cc      = in_c[8] ? 8'd0 : in_c[7:0];
    ab_diff = $signed({2'b00, in_a}) - $signed({2'b00, bc});
    c1_f    = (XW'({1'b0, {1'b0, in_a} + {1'b0, bc}}) <<< (F - 1)) - (XW'({1'b0, cc}) <<< F);
    c2_f    = KX_866 * XW'(ab_diff);
    if (direction == DIR_RGB_TO_ORGB) begin
      cx_n = c1_f;
      cy_n = c2_f;
    end else begin
      cx_n = XW'(in_b) <<< F;
      cy_n = XW'(in_c) <<< F;
    end
  end

  always_ff @(posedge clk) begin
    if (en[IDX_S1]) begin
      s1_lr    <= KL_R * LW'(in_a);
      s1_lg    <= KL_G * LW'(bc);
      s1_lb    <= KL_B * LW'(cc);
      s1_cx    <= cx_n;
      s1_cy    <= cy_n;
      sluma[0] <= in_a;
    end
  end

  // S2: luma rounding and vectoring setup
  logic [LW-1:0] lsum;
  logic [7:0]    luma_f;
  logic signed [XW-1:0] cy_abs;
  logic signed [XW-1:0]     vx [0:N];
  logic signed [XW-1:0]     vy [0:N];
  logic signed [ANG_W-1:0]  vz [0:N];

  always_comb begin
    lsum   = (s1_lr + s1_lg + s1_lb + RND_L) >> F;
    luma_f = (lsum > LW'(255)) ? 8'd255 : lsum[7:0];
    cy_abs = s1_cy[XW-1] ? -s1_cy : s1_cy;
  end

  always_ff @(posedge clk) begin
    if (en[IDX_S2]) begin
      sluma[IDX_S2] <= (direction == DIR_RGB_TO_ORGB) ? luma_f : sluma[0];
      sneg[IDX_S2]  <= s1_cy[XW-1];
      if (s1_cx[XW-1]) begin
        vx[0] <= cy_abs;
        vy[0] <= -s1_cx;
        vz[0] <= ANG_PI_2;
      end else begin
        vx[0] <= s1_cx;
        vy[0] <= cy_abs;
        vz[0] <= '0;
      end
    end
  end

  for (genvar k = IDX_S2 + 1; k <= IDX_P; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sluma[k] <= sluma[k-1];
        sneg[k]  <= sneg[k-1];
      end
    end
  end

  // vectoring CORDIC: angle of the chroma vector
  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [ANG_W-1:0] at;
    assign at = $signed(ANG_W'(ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (en[2 + i]) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + at;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - at;
        end
      end
    end
  end

  // R1: clamp angle, forward remap, inverse divide-by-3 product
  logic signed [ANG_W-1:0] zc, tf_n, dv_n;
  logic signed [ANG_W-1:0] r1_zc, r1_dv, r1_tf;
  logic signed [XW-1:0]    r1_x;
  logic [63:0]             r1_prod;
  logic                    r1_lo;

  always_comb begin
    if (vz[N] < 0)           zc = '0;
    else if (vz[N] > ANG_PI) zc = ANG_PI;
    else                     zc = vz[N];
    if (zc < ANG_PI_3) tf_n = zc + (zc >>> 1);
    else               tf_n = ANG_PI_2 + (((zc - ANG_PI_3) * 3) >>> 2);
    if (zc < ANG_PI_2) dv_n = zc + 2;
    else               dv_n = zc - ANG_PI_2;
  end

  always_ff @(posedge clk) begin
    if (en[IDX_R1]) begin
      r1_zc   <= zc;
      r1_dv   <= dv_n;
      r1_tf   <= tf_n;
      r1_lo   <= zc < ANG_PI_2;
      r1_x    <= vx[N];
      r1_prod <= 64'(dv_n[31:0]) * 64'(DIV3_MUL);
    end
  end

  // R2: target angle and rotation setup
  logic signed [ANG_W-1:0] q3, ti, tsel;
  logic signed [XW-1:0]     rx [0:N];
  logic signed [XW-1:0]     ry [0:N];
  logic signed [ANG_W-1:0]  rt [0:N];

  always_comb begin
    q3 = ANG_W'(r1_prod[63:33]);
    // 2z/3 = z - floor((z+2)/3); 4d/3 = d + floor(d/3)
    ti = r1_lo ? (r1_zc - q3) : (ANG_PI_3 + r1_dv + q3);
    tsel = (direction == DIR_RGB_TO_ORGB) ? r1_tf : ti;
  end

  always_ff @(posedge clk) begin
    if (en[IDX_R2]) begin
      if (tsel > ANG_PI_2) begin
        rx[0] <= '0;
        ry[0] <= r1_x;
        rt[0] <= tsel - ANG_PI_2;
      end else begin
        rx[0] <= r1_x;
        ry[0] <= '0;
        rt[0] <= tsel;
      end
    end
  end

  // rotation CORDIC
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [ANG_W-1:0] at;
    assign at = $signed(ANG_W'(ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (en[4 + N + i]) begin
        if (rt[i] >= 0) begin
          rx[i+1] <= rx[i] - (ry[i] >>> i);
          ry[i+1] <= ry[i] + (rx[i] >>> i);
          rt[i+1] <= rt[i] - at;
        end else begin
          rx[i+1] <= rx[i] + (ry[i] >>> i);
          ry[i+1] <= ry[i] - (rx[i] >>> i);
          rt[i+1] <= rt[i] + at;
        end
      end
    end
  end

  // G1/G2: remove both CORDIC gains, round, restore sign
  logic signed [GW-1:0] g1_x, g1_y, gy_r;
  logic signed [XW-1:0] q1, q2;

  always_ff @(posedge clk) begin
    if (en[IDX_G1]) begin
      g1_x <= GW'(rx[N]) * GAIN_S;
      g1_y <= GW'(ry[N]) * GAIN_S;
    end
  end

  assign gy_r = (g1_y + RND_G) >>> GAIN_BITS;

  always_ff @(posedge clk) begin
    if (en[IDX_G2]) begin
      q1 <= XW'((g1_x + RND_G) >>> GAIN_BITS);
      q2 <= sneg[IDX_G1] ? -XW'(gy_r) : XW'(gy_r);
    end
  end

  // P: inverse matrix products
  logic signed [PW-1:0] p_114, p_743, p_411, p_886, p_166;
  logic signed [XW-1:0] p_q1, p_q2;

  always_ff @(posedge clk) begin
    if (en[IDX_P]) begin
      p_114 <= PW'(q1) * KP_114;
      p_886 <= PW'(q1) * KP_886;
      p_743 <= PW'(q2) * KP_743;
      p_411 <= PW'(q2) * KP_411;
      p_166 <= PW'(q2) * KP_166;
      p_q1  <= q1;
      p_q2  <= q2;
    end
  end

  // O: final rounding and saturation
  logic signed [PW-1:0] lq, sr, sg, sb;
  logic signed [XW-1:0] fb, fc;
  logic [7:0]           o_a_n;
  logic signed [8:0]    o_b_n, o_c_n;
  logic [7:0]           res_a;
  logic signed [8:0]    res_b, res_c;

  always_comb begin
    lq = PW'({1'b0, sluma[IDX_P]}) <<< (2 * F);
    sr = (lq + p_114 + p_743 + RND_P) >>> (2 * F);
    sg = (lq + p_114 - p_411 + RND_P) >>> (2 * F);
    sb = (lq - p_886 + p_166 + RND_P) >>> (2 * F);
    fb = (p_q1 + RND_Q) >>> F;
    fc = (p_q2 + RND_Q) >>> F;
    if (direction == DIR_RGB_TO_ORGB) begin
      o_a_n = sluma[IDX_P];
      if (fb > 255)       o_b_n = 9'sd255;
      else if (fb < -255) o_b_n = -9'sd255;
      else                o_b_n = fb[8:0];
      if (fc > 255)       o_c_n = 9'sd255;
      else if (fc < -255) o_c_n = -9'sd255;
      else                o_c_n = fc[8:0];
    end else begin
      if (sr < 0)        o_a_n = 8'd0;
      else if (sr > 255) o_a_n = 8'd255;
      else               o_a_n = sr[7:0];
      if (sg < 0)        o_b_n = 9'sd0;
      else if (sg > 255) o_b_n = 9'sd255;
      else               o_b_n = {1'b0, sg[7:0]};
      if (sb < 0)        o_c_n = 9'sd0;
      else if (sb > 255) o_c_n = 9'sd255;
      else               o_c_n = {1'b0, sb[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[IDX_O]) begin
      res_a <= o_a_n;
      res_b <= o_b_n;
      res_c <= o_c_n;
    end
  end

  assign m_axis_tdata = {6'd0, res_c, res_b, res_a};

endmodule

/* bench/rgb_orgb_pixel_checker.sv */
module rgb_orgb_pixel_checker
  import orgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // chan_a[7:0], chan_b[16:8], chan_c[25:17], zero
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // res_a[7:0], res_b[16:8], res_c[25:17], zero
  output int          errors,
  output int          pending
);

  localparam int STAGES = 16;
  localparam int FRAC   = 14;

  dir_t        dir_q;
  logic [25:0] pixel_q[$];

  function automatic longint coef(input longint n, input longint d);
    return ((n << FRAC) + d / 2) / d;
  endfunction

  function automatic longint rnd(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // vector to angle, remap the angle, then rotate the magnitude back out
  function automatic void rotate_chroma(input longint cx, input longint cy, input bit inv,
                                        output longint ox, output longint oy);
    bit neg;
    longint x, y, z, t, dx, dy, at;
    longint unsigned g;
    neg = cy < 0;
    if (neg) cy = -cy;
    if (cx < 0) begin
      x = cy; y = -cx; z = longint'(ANG_PI_2);
    end else begin
      x = cx; y = cy; z = 0;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i; dy = x >>> i; at = longint'(ATAN_TAB[i]);
      if (y > 0) begin
        x += dx; y -= dy; z += at;
      end else begin
        x -= dx; y += dy; z -= at;
      end
    end
    z = sat(z, 0, longint'(ANG_PI));
    if (!inv)
      t = (z < longint'(ANG_PI_3)) ? (z * 3) / 2
        : longint'(ANG_PI_2) + ((z - longint'(ANG_PI_3)) * 3) / 4;
    else
      t = (z < longint'(ANG_PI_2)) ? (z * 2) / 3
        : longint'(ANG_PI_3) + ((z - longint'(ANG_PI_2)) * 4) / 3;
    if (t > longint'(ANG_PI_2)) begin
      y = x; x = 0; t -= longint'(ANG_PI_2);
    end else begin
      y = 0;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i; dy = x >>> i; at = longint'(ATAN_TAB[i]);
      if (t >= 0) begin
        x -= dx; y += dy; t -= at;
      end else begin
        x += dx; y -= dy; t += at;
      end
    end
    g = 64'd1 << GAIN_BITS;
    for (int i = 0; i < STAGES; i++) g = g - g / ((64'd1 << (2 * i)) + 64'd1);
    ox = rnd(x * longint'(g), GAIN_BITS);
    oy = rnd(y * longint'(g), GAIN_BITS);
    if (neg) oy = -oy;
  endfunction

  function automatic logic [25:0] convert_pixel(input dir_t d, input logic [25:0] px);
    longint a, b, c, ra, rb, rc, q1, q2, lq;
    logic signed [8:0] sb, sc;
    sb = px[16:8];
    sc = px[25:17];
    a = px[7:0];
    b = sb;
    c = sc;
    if (d == DIR_RGB_TO_ORGB) begin
      if (b < 0) b = 0;
      if (c < 0) c = 0;
      ra = sat(rnd(coef(2990, 10000) * a + coef(5870, 10000) * b + coef(1140, 10000) * c,
                   FRAC), 0, 255);
      rotate_chroma((a + b) * (longint'(1) << (FRAC - 1)) - c * (longint'(1) << FRAC),
                    coef(8660, 10000) * (a - b), 1'b0, q1, q2);
      rb = sat(rnd(q1, FRAC), -255, 255);
      rc = sat(rnd(q2, FRAC), -255, 255);
    end else begin
      lq = a << (2 * FRAC);
      rotate_chroma(b << FRAC, c << FRAC, 1'b1, q1, q2);
      ra = lq + coef(1140, 10000) * q1 + coef(743649, 1000000) * q2;
      rb = lq + coef(1140, 10000) * q1 - coef(411055, 1000000) * q2;
      rc = lq - coef(8860, 10000) * q1 + coef(166282, 1000000) * q2;
      ra = sat(rnd(ra, 2 * FRAC), 0, 255);
      rb = sat(rnd(rb, 2 * FRAC), 0, 255);
      rc = sat(rnd(rc, 2 * FRAC), 0, 255);
    end
    return {rc[8:0], rb[8:0], ra[7:0]};
  endfunction

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    logic [25:0] want;
    if (rst) begin
      dir_q <= DIR_RGB_TO_ORGB;
      errors <= 0;
      pixel_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION)
        dir_q <= dir_t'(pwdata[0]);
      if (s_axis_tvalid && s_axis_tready)
        pixel_q.push_back(convert_pixel(dir_q, s_axis_tdata[25:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected output transaction %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata[7:0] !== want[7:0] || m_axis_tdata[16:8] !== want[16:8] ||
              m_axis_tdata[25:17] !== want[25:17] || m_axis_tdata[31:26] !== 6'd0) begin
            $display("%0t: mismatch expected a=%0d b=%0d c=%0d actual a=%0d b=%0d c=%0d",
                     $time, want[7:0], $signed(want[16:8]), $signed(want[25:17]),
                     m_axis_tdata[7:0], $signed(m_axis_tdata[16:8]),
                     $signed(m_axis_tdata[25:17]));
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* bench/rgb_orgb_pixel_converter_unit_test.sv */
module rgb_orgb_pixel_converter_unit_test
  import orgb_pkg::*;
();

  localparam int LATENCY  = 2 * 16 + 8;
  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  int          errors, pending;
  int          idle_cycles;
  bit          steady, hold_req;

  rgb_orgb_pixel_converter_unit uut (.*);

  rgb_orgb_pixel_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 0;
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 0;
        repeat (200) @(negedge clk);
        hold_done = 1;
      end
      m_axis_tready <= steady || $urandom_range(99) >= 12;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_direction(input dir_t d);
    s_axis_tvalid <= 0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= ADDR_DIRECTION; pwdata <= {31'd0, d};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_pixel(input logic [7:0] a, input logic signed [8:0] b,
                            input logic signed [8:0] c);
    while (!steady && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, c, b, a};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
  endtask

  function automatic logic signed [8:0] any_chroma();
    return 9'($signed($urandom_range(510)) - 255);
  endfunction

  task automatic random_pixels(input int n, input dir_t d);
    for (int i = 0; i < n; i++) begin
      if (d == DIR_RGB_TO_ORGB && $urandom_range(3) != 0)
        send_pixel(8'($urandom_range(255)), 9'($urandom_range(255)),
                   9'($urandom_range(255)));
      else
        send_pixel(8'($urandom_range(255)), any_chroma(), any_chroma());
    end
  endtask

  initial begin
    rst = 1;
    steady = 0; hold_req = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    repeat (12) @(negedge clk);
    rst = 0;

    write_direction(DIR_RGB_TO_ORGB);
    // primaries, gray, extremes, negative inputs clamp to zero
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(10, -255, -1);
    send_pixel(200, -256, 40);
    send_pixel(255, 0, 255);
    random_pixels(200, DIR_RGB_TO_ORGB);

    write_direction(DIR_ORGB_TO_RGB);
    // zero chroma, chroma extremes and each quadrant
    send_pixel(0, 0, 0);
    send_pixel(255, 0, 0);
    send_pixel(128, 255, 255);
    send_pixel(128, -255, -255);
    send_pixel(128, 255, -255);
    send_pixel(128, -255, 255);
    send_pixel(0, -255, 0);
    send_pixel(255, 0, -255);
    send_pixel(100, 0, 1);
    send_pixel(100, -1, 0);
    steady = 1;
    hold_req = 1;
    random_pixels(150, DIR_ORGB_TO_RGB);
    steady = 0;
    random_pixels(100, DIR_ORGB_TO_RGB);

    write_direction(DIR_RGB_TO_ORGB);
    random_pixels(200, DIR_RGB_TO_ORGB);
    write_direction(DIR_ORGB_TO_RGB);
    random_pixels(180, DIR_ORGB_TO_RGB);
    s_axis_tvalid <= 0;

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
sv/orgb_pkg.sv
sv/rgb_orgb_pixel_converter_unit.sv
bench/rgb_orgb_pixel_checker.sv
bench/rgb_orgb_pixel_converter_unit_test.sv
